// ----- rtl/core/fnh_pkg.sv -----
// Shared types and constants for the font family name hash block.
// No dependencies.
`timescale 1ns / 1ps
package fnh_pkg;

  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;
  localparam int NS_MAX = 17;
  localparam int NS_SAT = 18;
  localparam int GEN_COUNT = 12;
  localparam int GEN_MAXLEN = 13;

  // One classified item passed from front to back.
  typedef struct packed {
    logic [7:0] lbyte;    // byte, ASCII lowercased
    logic       is_ws;
    logic       has_char;
    logic       last;
  } item_t;

  // Back status seen by the top level.
  typedef struct packed {
    logic matching;
    logic finishing;
  } stat_t;

endpackage

// ----- rtl/core/fnh_ifs.sv -----
// Channel interfaces for the font family name hash block.
// No dependencies.
`timescale 1ns / 1ps
interface fnh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       has_char;
  logic       last;
  modport source (output valid, char_byte, has_char, last, input ready);
  modport sink (input valid, char_byte, has_char, last, output ready);
endinterface

interface fnh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] name_hash;
  logic        is_generic;
  modport source (output valid, name_hash, is_generic, input ready);
  modport sink (input valid, name_hash, is_generic, output ready);
endinterface

// ----- rtl/core/fnh_front.sv -----
// Front: accepts raw bytes, classifies them and queues them for the back.
// Depends on fnh_pkg and fnh_ifs.
`timescale 1ns / 1ps
module fnh_front
  import fnh_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  fnh_in_if.sink in_ch,
  output logic   q_valid,
  input  logic   q_ready,
  output item_t  q_item
);

  item_t      fifo [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  item_t      cls;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    to_lower = (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
  endfunction

  always_comb begin
    cls.lbyte    = to_lower(in_ch.char_byte);
    cls.is_ws    = (in_ch.char_byte == 8'h20) ||
                   (in_ch.char_byte >= 8'h09 && in_ch.char_byte <= 8'h0d);
    cls.has_char = in_ch.has_char;
    cls.last     = in_ch.last;
  end

  assign in_ch.ready = (cnt != 2'd2);
  assign q_valid     = (cnt != 2'd0);
  assign q_item      = fifo[rp];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/core/fnh_back.sv -----
// Back: folds queued items into both hash hypotheses, checks generic names
// and holds the result. Depends on fnh_pkg and fnh_ifs.
`timescale 1ns / 1ps
module fnh_back
  import fnh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  item_t     q_item,
  fnh_out_if.source out_ch,
  output stat_t     stat
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BYTE  = 3'd1;
  localparam logic [2:0] ST_FIN   = 3'd2;
  localparam logic [2:0] ST_MATCH = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]  st;
  item_t       cur;
  logic [31:0] hu;
  logic [31:0] hs;
  logic        sp;
  logic        qp;
  logic [7:0]  pend;
  logic        pend_sp;
  logic        wrote;
  logic [7:0]  open_b;
  logic [7:0]  last_b;
  logic [7:0]  prev_b;
  logic [4:0]  cnt;
  logic [7:0]  tok [NS_MAX];
  logic        gap [NS_MAX];
  logic [1:0]  lo;
  logic [4:0]  len;
  logic [3:0]  gi;
  logic        gen;
  logic [31:0] res;
  logic        o_valid;
  logic [31:0] o_hash;
  logic        o_gen;
  logic        out_load;

  logic        strip;
  logic        layer2;
  logic        keep;
  logic [7:0]  sh [GEN_MAXLEN];
  logic        shgap [GEN_MAXLEN];
  logic [8*GEN_MAXLEN-1:0] gname;
  logic [4:0]  glen;
  logic        hit;

  function automatic logic [31:0] mix(input logic [31:0] h, input logic [7:0] b);
    mix = (h ^ {24'd0, b}) * FNV_PRIME;
  endfunction

  function automatic logic is_q(input logic [7:0] b);
    is_q = (b == 8'h22) || (b == 8'h27);
  endfunction

  assign q_ready        = (st == ST_IDLE);
  assign out_ch.valid      = o_valid;
  assign out_ch.name_hash  = o_hash;
  assign out_ch.is_generic = o_gen;
  assign stat.matching  = (st == ST_MATCH);
  assign stat.finishing = (st == ST_DONE);
  assign out_load       = (st == ST_DONE) && (!o_valid || out_ch.ready);

  // Quote layers and final selection.
  always_comb begin
    strip  = (cnt >= 5'd2) && (open_b == last_b) && is_q(open_b);
    layer2 = strip && (cnt >= 5'd4) && (tok[1] == prev_b) && is_q(tok[1]);
    keep   = strip ? (cnt > 5'd2) : (cnt != 5'd0);
  end

  // Generic name table, left-aligned.
  always_comb begin
    unique case (gi)
      4'd0:  begin gname = {"serif", 64'd0};         glen = 5'd5;  end
      4'd1:  begin gname = {"sans-serif", 24'd0};    glen = 5'd10; end
      4'd2:  begin gname = {"monospace", 32'd0};     glen = 5'd9;  end
      4'd3:  begin gname = {"cursive", 48'd0};       glen = 5'd7;  end
      4'd4:  begin gname = {"fantasy", 48'd0};       glen = 5'd7;  end
      4'd5:  begin gname = {"system-ui", 32'd0};     glen = 5'd9;  end
      4'd6:  begin gname = {"ui-serif", 40'd0};      glen = 5'd8;  end
      4'd7:  begin gname = {"ui-sans-serif"};        glen = 5'd13; end
      4'd8:  begin gname = {"ui-monospace", 8'd0};   glen = 5'd12; end
      4'd9:  begin gname = {"emoji", 64'd0};         glen = 5'd5;  end
      4'd10: begin gname = {"math", 72'd0};          glen = 5'd4;  end
      4'd11: begin gname = {"fangsong", 40'd0};      glen = 5'd8;  end
      default: begin gname = '0;                     glen = 5'd31; end
    endcase
  end

  // Shift the buffer by the stripped quote count and compare one name.
  always_comb begin
    hit = (len == glen);
    for (int j = 0; j < GEN_MAXLEN; j++) begin
      case (lo)
        2'd0:    begin sh[j] = tok[j];     shgap[j] = gap[j];     end
        2'd1:    begin sh[j] = tok[j + 1]; shgap[j] = gap[j + 1]; end
        default: begin sh[j] = tok[j + 2]; shgap[j] = gap[j + 2]; end
      endcase
      if (5'(j) < len && sh[j] != gname[8*GEN_MAXLEN-1-8*j -: 8]) hit = 1'b0;
      if (5'(j + 1) < len && shgap[j]) hit = 1'b0;
    end
  end

  // Result valid: set when a result loads, drop once it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ST_IDLE;
      hu      <= FNV_BASIS;
      hs      <= FNV_BASIS;
      sp      <= 1'b0;
      qp      <= 1'b0;
      pend_sp <= 1'b0;
      wrote   <= 1'b0;
      open_b  <= 8'd0;
      last_b  <= 8'd0;
      prev_b  <= 8'd0;
      cnt     <= 5'd0;
      gen     <= 1'b0;
      gi      <= 4'd0;
      for (int i = 0; i < NS_MAX; i++) begin
        tok[i] <= 8'd0;
        gap[i] <= 1'b0;
      end
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            if (!q_item.has_char || q_item.is_ws) begin
              if (q_item.has_char) sp <= 1'b1;
              st <= q_item.last ? ST_FIN : ST_IDLE;
            end else begin
              // Fold deferred spaces first.
              if (sp && cnt != 5'd0) hu <= mix(hu, 8'h20);
              if (cnt != 5'd0 && qp && pend_sp && wrote) hs <= mix(hs, 8'h20);
              st <= ST_BYTE;
            end
          end
        end
        ST_BYTE: begin
          hu <= mix(hu, cur.lbyte);
          if (cnt == 5'd0) begin
            open_b <= cur.lbyte;
          end else begin
            if (qp) begin
              hs    <= mix(hs, pend);
              wrote <= 1'b1;
            end
            pend    <= cur.lbyte;
            pend_sp <= sp;
            qp      <= 1'b1;
          end
          for (int i = 0; i < NS_MAX; i++) begin
            if (cnt == 5'(i)) begin
              tok[i] <= cur.lbyte;
              if (i > 0) gap[i - 1] <= sp;
            end
          end
          if (cnt < 5'(NS_SAT)) cnt <= cnt + 5'd1;
          prev_b <= last_b;
          last_b <= cur.lbyte;
          sp     <= 1'b0;
          st     <= cur.last ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          gen <= 1'b0;
          gi  <= 4'd0;
          res <= keep ? (strip ? hs : hu) : 32'd0;
          lo  <= {layer2, strip && !layer2};
          len <= cnt - {3'd0, strip, 1'b0} - {3'd0, layer2, 1'b0};
          st  <= (keep && cnt <= 5'(NS_MAX)) ? ST_MATCH : ST_DONE;
        end
        ST_MATCH: begin
          if (hit) gen <= 1'b1;
          if (gi == 4'(GEN_COUNT - 1)) st <= ST_DONE;
          else gi <= gi + 4'd1;
        end
        ST_DONE: begin
          if (out_load) begin
            o_hash  <= gen ? 32'd0 : res;
            o_gen   <= gen;
            hu      <= FNV_BASIS;
            hs      <= FNV_BASIS;
            sp      <= 1'b0;
            qp      <= 1'b0;
            pend_sp <= 1'b0;
            wrote   <= 1'b0;
            open_b  <= 8'd0;
            last_b  <= 8'd0;
            prev_b  <= 8'd0;
            cnt     <= 5'd0;
            gen     <= 1'b0;
            for (int i = 0; i < NS_MAX; i++) begin
              tok[i] <= 8'd0;
              gap[i] <= 1'b0;
            end
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/font_family_name_hash.sv -----
// Top level of the font family name hash block.
// Depends on fnh_pkg, fnh_ifs, fnh_front and fnh_back.
`timescale 1ns / 1ps
// Feed a font family name one byte per item on in_ch; the item with last set
// closes the name and yields one result on out_ch: the 32-bit FNV-1a hash of
// the normalized name (trimmed, one outer quote pair stripped, whitespace runs
// collapsed, ASCII lowercased), or zero with is_generic set when the name is a
// CSS generic family, or zero for an empty name. A two-item queue sits between
// the classifying front and the hashing back. Each non-space byte passes two
// steps in the back (space fold, then byte fold, one constant multiply each);
// whitespace and empty items take one step. The closing item passes the
// finish and done states and, when the name is short enough to be generic,
// a scan of the twelve generic names, one per cycle. The result register lets
// the next name begin while a result waits. No clearing pass after reset.
module font_family_name_hash
  import fnh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fnh_in_if.sink     in_ch,
  fnh_out_if.source  out_ch
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;
  stat_t stat;

  // Classify and queue raw bytes.
  fnh_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  // Hash, check generic names, hold the result.
  fnh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch),
    .stat    (stat)
  );

`ifndef SYNTHESIS
  // A generic match always reports a zero hash.
  a_gen_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.is_generic |-> out_ch.name_hash == 32'd0)
    else $error("generic result with nonzero hash");

  // Hold the queue head while the back is busy.
  a_q_hold: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |=> q_valid)
    else $error("queue dropped an item");

  // Pull nothing during the generic scan or while a result waits to load.
  a_no_pull: assert property (@(posedge clk) disable iff (rst)
    stat.matching || stat.finishing |-> !q_ready)
    else $error("back pulled an item while finishing a name");
`endif

endmodule
